@@ rtl/core/dseq_pkg.sv @@
// package for the date sorted entry queue: entry layout, codes, sizes
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dseq_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int FILL_W   = 6;
  localparam int KEY_W    = 34;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // first member lands in the top bits, so the date key is entry[49:16]
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_INSERT    = 2'd0,
    MODE_POP_FIRST = 2'd1,
    MODE_POP_LAST  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } dseq_cmd_t;

  function automatic logic [KEY_W-1:0] key_of(input entry_t e);
    key_of = {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dseq_ctrl.sv @@
// controller for the date sorted entry queue: two-state sequencer and output valid
// depends on dseq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dseq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output dseq_pkg::dseq_cmd_t  cmd
);
  import dseq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result slot free or being emptied this cycle
        if (!out_valid_r || out_tready) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/dseq_datapath.sv @@
// datapath for the date sorted entry queue: entry cells, parallel compare, shift, result register
// depends on dseq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dseq_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dseq_pkg::dseq_cmd_t  cmd,
  input  wire dseq_pkg::mode_t      in_mode,
  input  wire dseq_pkg::entry_t     in_entry,
  output dseq_pkg::status_t         res_status,
  output dseq_pkg::entry_t          res_entry,
  output logic [dseq_pkg::FILL_W-1:0] res_fill
);
  import dseq_pkg::*;

  entry_t               cells_r [CAPACITY];
  entry_t               cells_nxt [CAPACITY];
  logic [CNT_W-1:0]     count_r, count_nxt;
  mode_t                mode_r;
  entry_t               new_r;
  logic [CAPACITY-1:0]  at_r, at_nxt;
  status_t              status_r, status_nxt;
  entry_t               res_r, res_nxt;
  logic [FILL_W-1:0]    fill_r;
  logic [CNT_W-1:0]     last_pos;
  logic                 head_first;
  logic                 is_full, is_empty;

  // at_nxt[j]: new entry lands at or before cell j; thermometer since cells stay sorted
  always_comb begin
    head_first = (count_r == '0) || (key_of(in_entry) < key_of(cells_r[0]));
    at_nxt[0]  = head_first;
    for (int j = 1; j < CAPACITY; j++) begin
      at_nxt[j] = head_first || (CNT_W'(j) >= count_r)
                  || (key_of(cells_r[j]) >= key_of(in_entry));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      new_r  <= in_entry;
      at_r   <= at_nxt;
    end
  end

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign last_pos = count_r - CNT_W'(1);

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cells_nxt[j] = cells_r[j];
    end
    count_nxt  = count_r;
    status_nxt = STAT_DONE;
    res_nxt    = '0;
    case (mode_r)
      MODE_INSERT: begin
        if (is_full) begin
          status_nxt = STAT_FULL;
        end else begin
          if (at_r[0]) begin
            cells_nxt[0] = new_r;
          end
          for (int j = 1; j < CAPACITY; j++) begin
            if (at_r[j-1]) begin
              cells_nxt[j] = cells_r[j-1];
            end else if (at_r[j]) begin
              cells_nxt[j] = new_r;
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP_FIRST: begin
        if (is_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          res_nxt = cells_r[0];
          for (int j = 0; j < CAPACITY - 1; j++) begin
            cells_nxt[j] = cells_r[j+1];
          end
          count_nxt = last_pos;
        end
      end
      MODE_POP_LAST: begin
        if (is_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          res_nxt   = cells_r[last_pos[IDX_W-1:0]];
          count_nxt = last_pos;
        end
      end
      default: begin
        status_nxt = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int j = 0; j < CAPACITY; j++) begin
        cells_r[j] <= cells_nxt[j];
      end
      status_r <= status_nxt;
      res_r    <= res_nxt;
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign res_status = status_r;
  assign res_entry  = res_r;
  assign res_fill   = fill_r;

endmodule

`default_nettype wire

@@ rtl/core/date_sorted_entry_queue.sv @@
// top level of the date sorted entry queue: stream ports, controller and datapath
// depends on dseq_pkg, dseq_ctrl, dseq_datapath
//
// usage
// - input channel in_*: one transaction is one operation; in_tuser carries the mode
//   (insert sorted, remove earliest, remove latest, code 3 does nothing) and
//   in_tdata the date key and tag of an entry to insert (ignored on removals)
// - result channel out_*: exactly one transaction per operation; out_tuser carries
//   the status (done, empty on remove, full on insert), out_tdata the removed
//   entry (zero when nothing was removed) and the fill level after the operation
// - entries sit in a row of cells sorted by year, month, day, hour, minute; an
//   insert compares the new key with every cell at once and shifts the later
//   cells up by one, a remove-earliest shifts all cells down by one
// - the compare is registered at acceptance; the shift plus the result register
//   load happen in the execute step that follows, which waits while the result
//   register is still held, and out_tvalid is registered with the result; a new
//   operation is taken only after the execute step, set by the two-step compare
//   then shift sequence
// - reset (rst_n low, synchronous) empties the table; cell contents are not cleared
//   and are never read beyond the fill level
// - a stalled receiver holds the result in the output register; the next input
//   transaction is still taken and waits in the execute step until the result
//   register is free
`timescale 1ns / 1ps
`default_nettype none

module date_sorted_entry_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] tag[49:34] zero[55:50]
  input  wire logic [dseq_pkg::IN_TDATA_W-1:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] tag[49:34] fill[55:50]
  output logic [dseq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]       out_tuser
);
  import dseq_pkg::*;

  dseq_cmd_t         cmd;
  entry_t            in_entry;
  entry_t            res_entry;
  status_t           res_status;
  logic [FILL_W-1:0] res_fill;

  // unpack the input transaction into the entry layout
  assign in_entry.year   = in_tdata[13:0];
  assign in_entry.month  = in_tdata[17:14];
  assign in_entry.day    = in_tdata[22:18];
  assign in_entry.hour   = in_tdata[27:23];
  assign in_entry.minute = in_tdata[33:28];
  assign in_entry.tag    = in_tdata[49:34];

  dseq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dseq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (mode_t'(in_tuser)),
    .in_entry   (in_entry),
    .res_status (res_status),
    .res_entry  (res_entry),
    .res_fill   (res_fill)
  );

  // pack the result transaction
  assign out_tdata = {res_fill, res_entry.tag, res_entry.minute, res_entry.hour,
                      res_entry.day, res_entry.month, res_entry.year};
  assign out_tuser = res_status;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for date_sorted_entry_queue: directed, back-pressure and random tests
// depends on dseq_pkg and the block rtl; results are predicted by a table model kept here

module testbench;
  import dseq_pkg::*;

  // selector code that the package leaves unnamed: no operation
  localparam logic [1:0] MODE_NOP = 2'd3;
  // settling allowance for the path through the block, with some margin
  localparam int LATENCY_CYCLES = 4;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 222;
  localparam int HOLD_OFF_CYCLES = 120;

  // one expected result transaction
  typedef struct {
    logic [1:0]        status;
    entry_t            ent;
    logic [FILL_W-1:0] fill;
  } op_result_t;

  // clock, reset and block ports
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // predicted table contents, sorted by date key, and its fill level
  entry_t table_entries [CAPACITY];
  int     table_fill = 0;

  // results still owed by the block, oldest first
  op_result_t expected_results [$];

  // traffic shaping, percent of cycles spent idle on each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold-off, picked up by the receiver process
  int hold_request = 0;
  int hold_left = 0;

  // tallies
  int error_count = 0;
  int ops_sent = 0;
  int results_checked = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int quiet_cycles = 0;

  date_sorted_entry_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // year is the most significant part of the key, minute the least
  function automatic logic [KEY_W-1:0] date_key(entry_t e);
    return {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

  // apply one operation to the predicted table and return the result it owes
  function automatic op_result_t apply_operation(logic [1:0] mode, entry_t e);
    op_result_t r;
    int pos;
    r.status = STAT_DONE;
    r.ent = '0;
    case (mode)
      MODE_INSERT: begin
        if (table_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // front only when strictly earlier than the head
          if (table_fill == 0 || date_key(e) < date_key(table_entries[0])) begin
            pos = 0;
          end else begin
            // first later-or-equal entry from index 1, scanning back finds the lowest
            pos = table_fill;
            for (int j = table_fill - 1; j >= 1; j--)
              if (date_key(table_entries[j]) >= date_key(e)) pos = j;
          end
          for (int j = table_fill; j > pos; j--)
            table_entries[j] = table_entries[j - 1];
          table_entries[pos] = e;
          table_fill++;
        end
      end
      MODE_POP_FIRST: begin
        if (table_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.ent = table_entries[0];
          for (int j = 1; j < table_fill; j++)
            table_entries[j - 1] = table_entries[j];
          table_fill--;
        end
      end
      MODE_POP_LAST: begin
        if (table_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.ent = table_entries[table_fill - 1];
          table_fill--;
        end
      end
      default: begin
        // no operation, table untouched
      end
    endcase
    r.fill = FILL_W'(table_fill);
    return r;
  endfunction

  function automatic entry_t make_entry(int y, int mo, int d, int h, int mi, int tg);
    entry_t e;
    e.year = 14'(y);
    e.month = 4'(mo);
    e.day = 5'(d);
    e.hour = 5'(h);
    e.minute = 6'(mi);
    e.tag = 16'(tg);
    return e;
  endfunction

  // half the keys fall in a narrow window so that equal keys are common
  function automatic entry_t random_entry();
    entry_t e;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      e.year = 14'(2020 + $urandom_range(2));
      e.month = 4'($urandom_range(2, 1));
      e.day = 5'($urandom_range(3, 1));
      e.hour = 5'($urandom_range(1));
      e.minute = 6'($urandom_range(2));
    end else if (pick < 85) begin
      e.year = 14'($urandom_range(9999));
      e.month = 4'($urandom_range(12, 1));
      e.day = 5'($urandom_range(31, 1));
      e.hour = 5'($urandom_range(23));
      e.minute = 6'($urandom_range(59));
    end else begin
      // any bit pattern, out-of-range parts included
      e.year = 14'($urandom);
      e.month = 4'($urandom);
      e.day = 5'($urandom);
      e.hour = 5'($urandom);
      e.minute = 6'($urandom);
    end
    e.tag = 16'($urandom);
    return e;
  endfunction

  // offer one operation from a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back items lower it in between only for idle draws
  task automatic send_operation(input logic [1:0] mode, input entry_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    // year in the lowest bits, zero padding on top
    in_tdata <= {6'b0, e.tag, e.minute, e.hour, e.day, e.month, e.year};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(apply_operation(mode, e));
    ops_sent++;
    @(negedge clk);
  endtask

  // stop offering, let every owed result arrive, then allow the pipeline to settle
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: error: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // empty-table removals, the extremes of the key, equal keys, both removal ends
  // and the no-operation code on an empty and on a filled table
  task automatic test_corner_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_operation(MODE_POP_FIRST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_POP_LAST, make_entry(16383, 15, 31, 31, 63, 65535));
    send_operation(MODE_NOP, make_entry(16383, 15, 31, 31, 63, 65535));
    // one-entry table emptied from the back, then from the front
    send_operation(MODE_INSERT, make_entry(9999, 12, 31, 23, 59, 65535));
    send_operation(MODE_POP_LAST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_INSERT, make_entry(0, 1, 1, 0, 0, 0));
    send_operation(MODE_POP_FIRST, make_entry(0, 0, 0, 0, 0, 0));
    // equal keys: second goes to the end, third slots in after the head
    send_operation(MODE_INSERT, make_entry(2024, 6, 15, 12, 30, 16'h0001));
    send_operation(MODE_INSERT, make_entry(2024, 6, 15, 12, 30, 16'h0002));
    send_operation(MODE_INSERT, make_entry(2024, 6, 15, 12, 30, 16'h0003));
    // all-zero pattern lands at the front, all-ones pattern at the back
    send_operation(MODE_INSERT, make_entry(0, 0, 0, 0, 0, 16'h5a5a));
    send_operation(MODE_INSERT, make_entry(16383, 15, 31, 31, 63, 16'ha5a5));
    send_operation(MODE_NOP, make_entry(1, 1, 1, 1, 1, 1));
    send_operation(MODE_POP_FIRST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_POP_LAST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_POP_FIRST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_POP_LAST, make_entry(0, 0, 0, 0, 0, 0));
    send_operation(MODE_POP_FIRST, make_entry(0, 0, 0, 0, 0, 0));
    wait_until_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up;
  // the table is filled past capacity and then emptied past zero
  task automatic test_full_table_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < CAPACITY + 2; i++)
      send_operation(MODE_INSERT, random_entry());
    for (int i = 0; i < CAPACITY + 1; i++)
      send_operation((i % 2) ? MODE_POP_LAST : MODE_POP_FIRST, random_entry());
    wait_until_drained();
  endtask

  // mostly well-formed fill and drain sweeps with random keys, plus some noise
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int count);
    logic [1:0] mode;
    int pick;
    bit filling;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      // turn round at the ends, sometimes only after a refused operation
      if (table_fill >= CAPACITY && $urandom_range(1)) filling = 1'b0;
      if (table_fill == 0 && $urandom_range(1)) filling = 1'b1;
      if ($urandom_range(99) < 3) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 4)
        mode = MODE_NOP;
      else if (pick < 10)
        mode = 2'($urandom_range(3));
      else if ($urandom_range(99) < (filling ? 70 : 30))
        mode = MODE_INSERT;
      else
        mode = $urandom_range(1) ? MODE_POP_FIRST : MODE_POP_LAST;
      send_operation(mode, random_entry());
    end
    wait_until_drained();
  endtask

  // receiver: random ready at the falling edge, or a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // checker: every result transaction against the oldest expectation
  always @(posedge clk) begin
    op_result_t want;
    entry_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.year = out_tdata[13:0];
      got.month = out_tdata[17:14];
      got.day = out_tdata[22:18];
      got.hour = out_tdata[27:23];
      got.minute = out_tdata[33:28];
      got.tag = out_tdata[49:34];
      if (out_tuser == STAT_FULL) full_seen++;
      if (out_tuser == STAT_EMPTY) empty_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result transaction with nothing owed, tdata %0h", out_tdata));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("status", out_tuser, want.status);
        check_field("year", got.year, want.ent.year);
        check_field("month", got.month, want.ent.month);
        check_field("day", got.day, want.ent.day);
        check_field("hour", got.hour, want.ent.hour);
        check_field("minute", got.minute, want.ent.minute);
        check_field("tag", got.tag, want.ent.tag);
        check_field("fill", out_tdata[55:50], want.fill);
      end
    end
  end

  // watchdog: too long without any transaction means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results owed",
               quiet_cycles, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // reset held low from the start, released at a falling edge
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_full_table_backpressure();
    // sender lightly throttled and receiver mostly stalled, then the reverse, then flat out
    test_random_traffic(34, 82, RANDOM_PER_PHASE);
    test_random_traffic(82, 34, RANDOM_PER_PHASE);
    test_random_traffic(0, 0, RANDOM_PER_PHASE);

    $display("run covered %0d operations and %0d checked results", ops_sent, results_checked);
    $display("including %0d inserts refused on a full table and %0d removals on an empty one",
             full_seen, empty_seen);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
